// ===== src/rgbhsv_pkg.sv =====
// shared types and constants for the rgb to hsv pixel core
// no dependencies; used by rgbhsv_div and rgb_to_hsv_pixel_core

package rgbhsv_pkg;

    localparam int CH_W          = 8;
    localparam int HUE_W         = 15;
    localparam int HUE_FRAC_BITS = 6;

    // hue scale of 60 degrees and full circle, in fractional degree units
    localparam int HUE_SCALE = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;

    // hue numerator magnitude is at most 5 * 255, scaled numerator follows
    localparam int MAG_W  = 11;
    localparam int NHUE_W = MAG_W + 12;
    localparam int NSAT_W = 2 * CH_W;

    localparam int DIV_STAGES = 4;

    // work carried through the divider: partial remainder and a word that
    // holds unused dividend bits above and finished quotient bits below
    typedef struct packed {
        logic [CH_W-1:0]  rem_h;
        logic [HUE_W-1:0] work_h;
        logic [CH_W-1:0]  rem_s;
        logic [CH_W-1:0]  work_s;
        logic [CH_W-1:0]  delta;
        logic [CH_W-1:0]  mx;
        logic             neg;
    } div_work_t;

endpackage

// ===== src/rgbhsv_div.sv =====
// pipelined restoring divider for hue and saturation, four stages
// depends on rgbhsv_pkg (div_work_t, widths)

module rgbhsv_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rgbhsv_pkg::div_work_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rgbhsv_pkg::div_work_t  out_data
);

    localparam int NSTG = rgbhsv_pkg::DIV_STAGES;

    // quotient bits resolved per stage: hue 3+4+4+4 = 15, saturation 4x2 = 8
    localparam int HUE_STEPS [NSTG] = '{3, 4, 4, 4};
    localparam int SAT_STEPS [NSTG] = '{2, 2, 2, 2};

    // one compare and subtract; returns {new remainder, quotient bit}
    function automatic logic [rgbhsv_pkg::CH_W:0] div_step(
        input logic [rgbhsv_pkg::CH_W-1:0] rem,
        input logic                        nbit,
        input logic [rgbhsv_pkg::CH_W-1:0] d
    );
        logic [rgbhsv_pkg::CH_W:0] t;
        logic [rgbhsv_pkg::CH_W:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {diff[rgbhsv_pkg::CH_W-1:0], 1'b1};
        end else begin
            return {t[rgbhsv_pkg::CH_W-1:0], 1'b0};
        end
    endfunction

    logic                  valid_reg [NSTG];
    rgbhsv_pkg::div_work_t data_reg  [NSTG];
    logic                  stg_ready [NSTG];
    rgbhsv_pkg::div_work_t data_next [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        rgbhsv_pkg::div_work_t stg_in;
        logic                  stg_valid_in;

        if (s == 0) begin : g_first
            assign stg_in       = in_data;
            assign stg_valid_in = in_valid;
        end else begin : g_rest
            assign stg_in       = data_reg[s-1];
            assign stg_valid_in = valid_reg[s-1];
        end

        if (s == NSTG - 1) begin : g_last
            assign stg_ready[s] = !valid_reg[s] || out_ready;
        end else begin : g_mid
            assign stg_ready[s] = !valid_reg[s] || stg_ready[s+1];
        end

        always_comb begin
            rgbhsv_pkg::div_work_t w;
            logic [rgbhsv_pkg::CH_W:0] r;
            w = stg_in;
            r = '0;
            for (int j = 0; j < 4; j++) begin
                if (j < HUE_STEPS[s]) begin
                    r        = div_step(w.rem_h, w.work_h[rgbhsv_pkg::HUE_W-1], w.delta);
                    w.rem_h  = r[rgbhsv_pkg::CH_W:1];
                    w.work_h = {w.work_h[rgbhsv_pkg::HUE_W-2:0], r[0]};
                end
                if (j < SAT_STEPS[s]) begin
                    r        = div_step(w.rem_s, w.work_s[rgbhsv_pkg::CH_W-1], w.mx);
                    w.rem_s  = r[rgbhsv_pkg::CH_W:1];
                    w.work_s = {w.work_s[rgbhsv_pkg::CH_W-2:0], r[0]};
                end
            end
            data_next[s] = w;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stg_ready[s]) begin
                valid_reg[s] <= stg_valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (stg_ready[s] && stg_valid_in) begin
                data_reg[s] <= data_next[s];
            end
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_data  = data_reg[NSTG-1];

endmodule

// ===== src/rgb_to_hsv_pixel_core.sv =====
// rgb to hsv pixel converter, top level
// depends on rgbhsv_pkg and rgbhsv_div

// usage
//  - slave stream s_*: one word per pixel, red in tdata[7:0], green in
//    tdata[15:8], blue in tdata[23:16]
//  - master stream m_*: one word per pixel, hue in tdata[14:0] (1/64 degree
//    units), saturation in tdata[22:15], brightness in tdata[30:23]
//  - pixels leave in the order they arrive, one result word per input word
//  - throughput: one pixel per clock while the receiver keeps taking words; four front
//    stages (max/min, delta and channel difference, sector numerator, hue scaling), four
//    divider stages (hue quotient 3-4 bits and saturation 2 bits per stage), one output stage
//  - every stage holds a valid bit; a stage takes a new word when it is empty
//    or its successor moves, so bubbles fill up while the receiver stalls
//  - s_tready stays high while any stage up to the first has room, even when
//    a finished word waits on m_tready
//  - a stall loses and repeats nothing: held words stay in their stages
//  - reset (aresetn low at an edge) empties every stage; no pixel state
//    carries over between words

module rgb_to_hsv_pixel_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hue[14:0], saturation[22:15], brightness[30:23], 0
);

    localparam int CW = rgbhsv_pkg::CH_W;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // handshake chain, back to front
    logic st1_ready, st2_ready, st3_ready, st4_ready, out_ready;
    logic div_in_ready, div_out_valid;
    rgbhsv_pkg::div_work_t div_out;

    // stage valid bits
    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg, out_valid_reg;

    // input channels
    logic [CW-1:0] red_in, green_in, blue_in;
    assign red_in   = s_tdata[7:0];
    assign green_in = s_tdata[15:8];
    assign blue_in  = s_tdata[23:16];

    assign out_ready = !out_valid_reg || m_tready;
    assign st4_ready = !st4_valid_reg || div_in_ready;
    assign st3_ready = !st3_valid_reg || st4_ready;
    assign st2_ready = !st2_valid_reg || st3_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_tready  = st1_ready;

    // stage 1: max and min of the channels
    logic [CW-1:0] mx_rg, mn_rg, mx_next, mn_next;
    logic [CW-1:0] red1_reg, green1_reg, blue1_reg, mx1_reg, mn1_reg;

    always_comb begin
        mx_rg   = (red_in >= green_in) ? red_in : green_in;
        mn_rg   = (red_in <= green_in) ? red_in : green_in;
        mx_next = (mx_rg >= blue_in) ? mx_rg : blue_in;
        mn_next = (mn_rg <= blue_in) ? mn_rg : blue_in;
    end

    // stage 2: delta, sector (first channel equal to max wins), difference
    sector_t       sec_next, sec2_reg;
    logic [CW:0]   diff_next, diff2_reg;   // signed, two's complement
    logic [CW-1:0] delta_next, delta2_reg, mx2_reg;

    always_comb begin
        delta_next = mx1_reg - mn1_reg;
        if (mx1_reg == red1_reg) begin
            sec_next  = SEC_RED;
            diff_next = {1'b0, green1_reg} - {1'b0, blue1_reg};
        end else if (mx1_reg == green1_reg) begin
            sec_next  = SEC_GREEN;
            diff_next = {1'b0, blue1_reg} - {1'b0, red1_reg};
        end else begin
            sec_next  = SEC_BLUE;
            diff_next = {1'b0, red1_reg} - {1'b0, green1_reg};
        end
    end

    // stage 3: numerator magnitude and sign, saturation numerator
    logic [rgbhsv_pkg::MAG_W:0]    diff_ext, mag_ext, abs_ext;
    logic [rgbhsv_pkg::MAG_W-1:0]  mag_next, mag3_reg;
    logic                          neg_next, neg3_reg;
    logic [rgbhsv_pkg::NSAT_W-1:0] nsat_next, nsat3_reg;
    logic [CW-1:0]                 delta3_reg, mx3_reg;

    always_comb begin
        diff_ext = {{(rgbhsv_pkg::MAG_W - CW){diff2_reg[CW]}}, diff2_reg};
        abs_ext  = diff2_reg[CW] ? (~diff_ext + 1'b1) : diff_ext;
        neg_next = 1'b0;
        unique case (sec2_reg)
            SEC_RED: begin
                mag_ext  = abs_ext;
                neg_next = diff2_reg[CW];
            end
            SEC_GREEN: mag_ext = diff_ext + {3'b0, delta2_reg, 1'b0};
            SEC_BLUE:  mag_ext = diff_ext + {2'b0, delta2_reg, 2'b0};
            default:   mag_ext = diff_ext;
        endcase
        mag_next  = mag_ext[rgbhsv_pkg::MAG_W-1:0];
        nsat_next = {delta2_reg, {CW{1'b0}}} - {{CW{1'b0}}, delta2_reg};
    end

    // stage 4: scale hue numerator, load divider remainders
    logic [rgbhsv_pkg::NHUE_W-1:0] nhue;
    rgbhsv_pkg::div_work_t         work_next, work4_reg;

    always_comb begin
        nhue = rgbhsv_pkg::NHUE_W'(mag3_reg) *
               rgbhsv_pkg::NHUE_W'(rgbhsv_pkg::HUE_SCALE);
        // quotients fit their fields, so the top dividend bits sit below the divisor
        work_next.rem_h  = nhue[rgbhsv_pkg::NHUE_W-1:rgbhsv_pkg::HUE_W];
        work_next.work_h = nhue[rgbhsv_pkg::HUE_W-1:0];
        work_next.rem_s  = nsat3_reg[rgbhsv_pkg::NSAT_W-1:CW];
        work_next.work_s = nsat3_reg[CW-1:0];
        work_next.delta  = delta3_reg;
        work_next.mx     = mx3_reg;
        work_next.neg    = neg3_reg;
    end

    rgbhsv_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st4_valid_reg),
        .in_ready  (div_in_ready),
        .in_data   (work4_reg),
        .out_valid (div_out_valid),
        .out_ready (out_ready),
        .out_data  (div_out)
    );

    // output stage: gray pixels force hue and saturation to zero, since the
    // hue divider ran on a zero divisor; a negative red-sector hue wraps
    logic [rgbhsv_pkg::HUE_W-1:0] hue_next, hue_reg;
    logic [CW-1:0]                sat_next, sat_reg, bright_reg;

    always_comb begin
        sat_next = div_out.work_s;
        if (div_out.delta == '0) begin
            hue_next = '0;
            sat_next = '0;
        end else if (div_out.neg && (div_out.work_h != '0)) begin
            hue_next = rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_FULL) - div_out.work_h;
        end else begin
            hue_next = div_out.work_h;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) st1_valid_reg <= s_tvalid;
            if (st2_ready) st2_valid_reg <= st1_valid_reg;
            if (st3_ready) st3_valid_reg <= st2_valid_reg;
            if (st4_ready) st4_valid_reg <= st3_valid_reg;
            if (out_ready) out_valid_reg <= div_out_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (st1_ready && s_tvalid) begin
            red1_reg   <= red_in;
            green1_reg <= green_in;
            blue1_reg  <= blue_in;
            mx1_reg    <= mx_next;
            mn1_reg    <= mn_next;
        end
        if (st2_ready && st1_valid_reg) begin
            sec2_reg   <= sec_next;
            diff2_reg  <= diff_next;
            delta2_reg <= delta_next;
            mx2_reg    <= mx1_reg;
        end
        if (st3_ready && st2_valid_reg) begin
            mag3_reg   <= mag_next;
            neg3_reg   <= neg_next;
            nsat3_reg  <= nsat_next;
            delta3_reg <= delta2_reg;
            mx3_reg    <= mx2_reg;
        end
        if (st4_ready && st3_valid_reg) begin
            work4_reg <= work_next;
        end
        if (out_ready && div_out_valid) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= div_out.mx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, bright_reg, sat_reg, hue_reg};

endmodule

// ===== src/rgbhsv_checker.sv =====
// port-level checks for the rgb to hsv pixel core, bound to the top level
// depends on rgb_to_hsv_pixel_core port names only

module rgbhsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // hue stays inside one circle and the pad bit is zero
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:0] < 15'd23040) && !m_tdata[31])
        else $error("hue out of range");

    // zero saturation only for gray pixels, which carry zero hue
    a_gray_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[22:15] == 8'd0) |-> m_tdata[14:0] == 15'd0)
        else $error("gray pixel with nonzero hue");

    // black in gives black out
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[30:23] == 8'd0) |-> m_tdata[22:0] == 23'd0)
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel_core rgbhsv_checker u_rgbhsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
